// ===== sv/swbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window bandwidth shaper package
// Shared widths, register indexes, item and divider types and a ring index helper.
// ----------------------------------------------------------------------------
package swbs_pkg;

   localparam int SLOTS      = 128;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int LEN_W      = 32;
   localparam int BYTE_W     = 48;
   localparam int TIME_W     = 32;
   localparam int WAIT_W     = 22;
   localparam int CAP_W      = 44;
   localparam int KEEP_W     = 22;
   localparam int DIVC_W     = $clog2(CAP_W + 1);
   localparam int RATE_W     = 32;
   localparam int WS_W       = 12;
   localparam int SLOTMS_W   = 16;
   localparam int LAT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KEEP_W-1:0] MS_PER_S = KEEP_W'(1000);

   localparam logic [CSR_IDX_W-1:0] CSR_RATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATENCY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_READ    = 3'd5;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_REQ  = 2'd1,
      FUNC_CMP  = 2'd2,
      FUNC_EVT  = 2'd3
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [LEN_W-1:0]  length;
      logic              would_block;
   } item_type;

   typedef struct packed {
      logic              start;
      logic [CAP_W-1:0]  dividend;
      logic [KEEP_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CAP_W-1:0]  quotient;
   } div_rsp_type;

   function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(SLOTS)) begin
         sum = sum - (CNT_W + 1)'(SLOTS);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== sv/swbs_div.sv =====
// ----------------------------------------------------------------------------
// Sliding window bandwidth shaper divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swbs_div import swbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic [CAP_W-1:0]  dvd_ff, dvd_in;
   logic [KEEP_W-1:0] dvs_ff, dvs_in;
   logic [KEEP_W-1:0] rem_ff, rem_in;
   logic [KEEP_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[CAP_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIVC_W'(CAP_W);
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = KEEP_W'(trial - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[CAP_W-2:0], 1'b1};
         end else begin
            rem_in = trial[KEEP_W-1:0];
            dvd_in = {dvd_ff[CAP_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIVC_W'(1);
         if (cnt_ff == DIVC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// ===== sv/swbs_front.sv =====
// ----------------------------------------------------------------------------
// Sliding window bandwidth shaper front end
// Accepts requests, decodes the function code and queues them for the back end.
// ----------------------------------------------------------------------------
module swbs_front import swbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [LEN_W-1:0] req_length,
   input  logic             req_would_block,
   output logic             q_valid,
   output item_type         q_item,
   input  logic             q_pop
);

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   item_type   new_item;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = ent_ff[rd_ptr_ff];

   always_comb begin
      new_item.func        = func_type'(req_func);
      new_item.length      = req_length;
      new_item.would_block = req_would_block && (func_type'(req_func) == FUNC_CMP);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      fill_in   = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== sv/swbs_back.sv =====
// ----------------------------------------------------------------------------
// Sliding window bandwidth shaper back end
// Sequencer that keeps the slot ring, evaluates budgets and waits, and
// produces one response per request.
// ----------------------------------------------------------------------------
module swbs_back import swbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEN_W-1:0]      rsp_grant,
   output logic                  rsp_blocked,
   output logic [WAIT_W-1:0]     rsp_wait_ms,
   output logic                  rsp_wait_infinite,
   output logic                  rsp_deliver_event,
   output logic                  rsp_waiting_flag,
   output logic [BYTE_W-1:0]     rsp_total_bytes
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_PMUL  = 13'b0000000000010,
      ST_PDIV1 = 13'b0000000000100,
      ST_PDIV2 = 13'b0000000001000,
      ST_EXEC  = 13'b0000000010000,
      ST_TMO   = 13'b0000000100000,
      ST_EXPRD = 13'b0000001000000,
      ST_EXPCK = 13'b0000010000000,
      ST_BUD   = 13'b0000100000000,
      ST_RAPP  = 13'b0001000000000,
      ST_WAIT  = 13'b0010000000000,
      ST_DONE  = 13'b0100000000000,
      ST_OUT   = 13'b1000000000000
   } state_type;

   typedef enum logic [1:0] {
      PH_REQ = 2'd0,
      PH_EVT = 2'd1,
      PH_FIN = 2'd2
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [BYTE_W-1:0] bytes;
   } slot_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   item_type  item_ff, item_in;

   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                mode_ff, mode_in;
   logic [WS_W-1:0]     ws_ff, ws_in;
   logic [SLOTMS_W-1:0] slot_ff, slot_in;
   logic [LAT_W-1:0]    lat_ff, lat_in;
   logic                rside_ff, rside_in;
   logic                dirty_ff, dirty_in;

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [CAP_W-1:0]  pslot_ff, pslot_in;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] window_ff, window_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic              waiting_ff, waiting_in;
   logic              full_ff, full_in;
   logic [LEN_W-1:0]  granted_ff, granted_in;
   logic [BYTE_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0] ystart_ff, ystart_in;
   logic [BYTE_W-1:0] ybytes_ff, ybytes_in;

   logic [CAP_W-1:0]  bud_ff, bud_in;
   logic              bunl_ff, bunl_in;
   logic [WAIT_W-1:0] t_ff, t_in;
   logic              tunl_ff, tunl_in;
   logic [LEN_W-1:0]  grant_ff, grant_in;
   logic              blocked_ff, blocked_in;
   logic              deliver_ff, deliver_in;

   logic              rv_ff, rv_in;
   logic [LEN_W-1:0]  rgrant_ff, rgrant_in;
   logic              rblk_ff, rblk_in;
   logic [WAIT_W-1:0] rwait_ff, rwait_in;
   logic              rinf_ff, rinf_in;
   logic              rdel_ff, rdel_in;
   logic              rwflag_ff, rwflag_in;
   logic [BYTE_W-1:0] rtotal_ff, rtotal_in;

   slot_type          mem [SLOTS];
   slot_type          rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   slot_type          mem_wdata;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [TIME_W-1:0] age_last, age_young, age_head;
   logic              lw_zero;
   logic [LEN_W-1:0]  moved;
   logic              new_slot;
   logic [BYTE_W-1:0] used;
   logic [BYTE_W-1:0] cap_w, pslot_w;
   logic [TIME_W-1:0] bw_t, lw_t;
   logic [KEEP_W-1:0] pwin;

   swbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign age_last  = now_ff - last_ff;
   assign age_young = now_ff - ystart_ff;
   assign age_head  = now_ff - rd_ff.start;
   assign lw_zero   = (TIME_W'(lat_ff) <= age_last) || (rside_ff && full_ff);
   assign moved     = (item_ff.length > granted_ff) ? granted_ff : item_ff.length;
   assign new_slot  = (count_ff == '0) ||
                      ((age_young > TIME_W'(slot_ff)) && (count_ff < CNT_W'(SLOTS)));
   assign used      = ((count_ff != '0) && (age_young < TIME_W'(slot_ff))) ? ybytes_ff : '0;
   assign cap_w     = BYTE_W'(cap_ff);
   assign pslot_w   = BYTE_W'(pslot_ff);
   assign pwin      = (div_rsp.quotient == '0) ? KEEP_W'(1) : div_rsp.quotient[KEEP_W-1:0];
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      item_in    = item_ff;
      rate_in    = rate_ff;
      mode_in    = mode_ff;
      ws_in      = ws_ff;
      slot_in    = slot_ff;
      lat_in     = lat_ff;
      rside_in   = rside_ff;
      dirty_in   = dirty_ff;
      cap_in     = cap_ff;
      keep_in    = keep_ff;
      pslot_in   = pslot_ff;
      now_in     = now_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      window_in  = window_ff;
      last_in    = last_ff;
      waiting_in = waiting_ff;
      full_in    = full_ff;
      granted_in = granted_ff;
      total_in   = total_ff;
      ystart_in  = ystart_ff;
      ybytes_in  = ybytes_ff;
      bud_in     = bud_ff;
      bunl_in    = bunl_ff;
      t_in       = t_ff;
      tunl_in    = tunl_ff;
      grant_in   = grant_ff;
      blocked_in = blocked_ff;
      deliver_in = deliver_ff;
      rv_in      = rv_ff && !rsp_ready;
      rgrant_in  = rgrant_ff;
      rblk_in    = rblk_ff;
      rwait_in   = rwait_ff;
      rinf_in    = rinf_ff;
      rdel_in    = rdel_ff;
      rwflag_in  = rwflag_ff;
      rtotal_in  = rtotal_ff;
      mem_we     = 1'b0;
      mem_waddr  = head_ff;
      mem_wdata  = '0;
      div_req    = '0;
      bw_t       = '0;
      lw_t       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in    = q_item;
               grant_in   = '0;
               blocked_in = 1'b0;
               deliver_in = 1'b0;
               state_in   = dirty_ff ? ST_PMUL : ST_EXEC;
            end
         end
         ST_PMUL: begin
            cap_in           = CAP_W'(rate_ff) * CAP_W'(ws_ff);
            keep_in          = KEEP_W'(ws_ff) * MS_PER_S;
            div_req.start    = 1'b1;
            div_req.dividend = CAP_W'(KEEP_W'(ws_ff) * MS_PER_S);
            div_req.divisor  = (slot_ff == '0) ? KEEP_W'(1) : KEEP_W'(slot_ff);
            state_in         = ST_PDIV1;
         end
         ST_PDIV1: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = cap_ff;
               div_req.divisor  = pwin;
               state_in         = ST_PDIV2;
            end
         end
         ST_PDIV2: begin
            if (div_rsp.done) begin
               pslot_in = (div_rsp.quotient == '0) ? CAP_W'(1) : div_rsp.quotient;
               dirty_in = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            phase_in = PH_FIN;
            state_in = ST_TMO;
            case (item_ff.func)
               FUNC_TICK: begin
                  now_in = now_ff + TIME_W'(1);
               end
               FUNC_REQ: begin
                  if (lw_zero) begin
                     phase_in = PH_REQ;
                     state_in = ST_EXPRD;
                  end else begin
                     waiting_in = 1'b1;
                     blocked_in = 1'b1;
                     grant_in   = '0;
                     granted_in = '0;
                  end
               end
               FUNC_CMP: begin
                  if (item_ff.would_block) begin
                     full_in    = 1'b0;
                     waiting_in = (lat_ff != '0);
                  end else begin
                     total_in  = total_ff + BYTE_W'(moved);
                     last_in   = now_ff;
                     window_in = window_ff + BYTE_W'(moved);
                     mem_we    = 1'b1;
                     if (new_slot) begin
                        count_in  = count_ff + CNT_W'(1);
                        ystart_in = now_ff;
                        ybytes_in = BYTE_W'(moved);
                        mem_waddr = ring_idx(head_ff, count_ff);
                     end else begin
                        ybytes_in = ybytes_ff + BYTE_W'(moved);
                        mem_waddr = ring_idx(head_ff, count_ff - CNT_W'(1));
                     end
                     mem_wdata.start = ystart_in;
                     mem_wdata.bytes = ybytes_in;
                     if (moved < granted_ff) begin
                        full_in    = 1'b0;
                        waiting_in = (lat_ff != '0);
                     end
                  end
               end
               FUNC_EVT: begin
                  phase_in = PH_EVT;
               end
               default: begin
               end
            endcase
         end
         ST_TMO: begin
            if (((rate_ff == '0) && (lat_ff == '0)) || !waiting_ff) begin
               tunl_in  = 1'b1;
               t_in     = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_EXPRD;
            end
         end
         ST_EXPRD: begin
            state_in = ST_EXPCK;
         end
         ST_EXPCK: begin
            if ((count_ff != '0) && (age_head >= TIME_W'(keep_ff))) begin
               window_in = window_ff - rd_ff.bytes;
               head_in   = ring_idx(head_ff, CNT_W'(1));
               count_in  = count_ff - CNT_W'(1);
               state_in  = ST_EXPRD;
            end else begin
               state_in = ST_BUD;
            end
         end
         ST_BUD: begin
            bunl_in = (rate_ff == '0);
            if (!mode_ff) begin
               bud_in = (cap_w <= window_ff) ? '0 : CAP_W'(cap_w - window_ff);
            end else begin
               bud_in = (pslot_w <= used) ? '0 : CAP_W'(pslot_w - used);
            end
            state_in = (phase_ff == PH_REQ) ? ST_RAPP : ST_WAIT;
         end
         ST_RAPP: begin
            if (bunl_ff || (bud_ff != '0)) begin
               waiting_in = 1'b0;
               if (rside_ff) begin
                  full_in = 1'b1;
               end
               if (!bunl_ff && (CAP_W'(item_ff.length) > bud_ff)) begin
                  waiting_in = 1'b1;
                  full_in    = 1'b0;
                  grant_in   = bud_ff[LEN_W-1:0];
               end else begin
                  grant_in = item_ff.length;
               end
            end else begin
               waiting_in = 1'b1;
               blocked_in = 1'b1;
               grant_in   = '0;
            end
            granted_in = grant_in;
            phase_in   = PH_FIN;
            state_in   = ST_TMO;
         end
         ST_WAIT: begin
            if (bunl_ff || (bud_ff != '0) || (count_ff == '0)) begin
               bw_t = '0;
            end else if (!mode_ff) begin
               bw_t = (age_head >= TIME_W'(keep_ff)) ? '0 : TIME_W'(keep_ff) - age_head;
            end else begin
               bw_t = (age_young >= TIME_W'(slot_ff)) ? '0 : TIME_W'(slot_ff) - age_young;
            end
            if ((TIME_W'(lat_ff) < age_last) || (rside_ff && full_ff)) begin
               lw_t = '0;
            end else begin
               lw_t = TIME_W'(lat_ff) - age_last;
            end
            t_in     = (bw_t > lw_t) ? bw_t[WAIT_W-1:0] : lw_t[WAIT_W-1:0];
            tunl_in  = 1'b0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            case (phase_ff)
               PH_EVT: begin
                  if (tunl_ff) begin
                     deliver_in = 1'b1;
                  end else if (t_ff == '0) begin
                     deliver_in = 1'b1;
                     waiting_in = 1'b0;
                  end
                  phase_in = PH_FIN;
                  state_in = ST_TMO;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in     = 1'b1;
               rgrant_in = grant_ff;
               rblk_in   = blocked_ff;
               rwait_in  = tunl_ff ? '0 : t_ff;
               rinf_in   = tunl_ff;
               rdel_in   = deliver_ff;
               rwflag_in = waiting_ff;
               rtotal_in = total_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_en) begin
         case (csr_index)
            CSR_RATE: begin
               rate_in = csr_wdata[RATE_W-1:0];
            end
            CSR_MODE: begin
               mode_in = csr_wdata[0];
            end
            CSR_WINDOW: begin
               ws_in = csr_wdata[WS_W-1:0];
            end
            CSR_SLOT: begin
               slot_in = csr_wdata[SLOTMS_W-1:0];
            end
            CSR_LATENCY: begin
               lat_in  = csr_wdata[LAT_W-1:0];
               last_in = now_ff;
            end
            CSR_READ: begin
               rside_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
         if ((csr_index == CSR_RATE) || (csr_index == CSR_MODE) ||
             (csr_index == CSR_WINDOW) || (csr_index == CSR_SLOT)) begin
            head_in   = '0;
            count_in  = '0;
            window_in = '0;
            dirty_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_FIN;
         rate_ff    <= '0;
         mode_ff    <= 1'b0;
         ws_ff      <= WS_W'(10);
         slot_ff    <= SLOTMS_W'(100);
         lat_ff     <= '0;
         rside_ff   <= 1'b0;
         dirty_ff   <= 1'b1;
         now_ff     <= '0;
         head_ff    <= '0;
         count_ff   <= '0;
         window_ff  <= '0;
         last_ff    <= '0;
         waiting_ff <= 1'b0;
         full_ff    <= 1'b0;
         granted_ff <= '0;
         total_ff   <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         rate_ff    <= rate_in;
         mode_ff    <= mode_in;
         ws_ff      <= ws_in;
         slot_ff    <= slot_in;
         lat_ff     <= lat_in;
         rside_ff   <= rside_in;
         dirty_ff   <= dirty_in;
         now_ff     <= now_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         window_ff  <= window_in;
         last_ff    <= last_in;
         waiting_ff <= waiting_in;
         full_ff    <= full_in;
         granted_ff <= granted_in;
         total_ff   <= total_in;
         rv_ff      <= rv_in;
      end
      item_ff    <= item_in;
      cap_ff     <= cap_in;
      keep_ff    <= keep_in;
      pslot_ff   <= pslot_in;
      ystart_ff  <= ystart_in;
      ybytes_ff  <= ybytes_in;
      bud_ff     <= bud_in;
      bunl_ff    <= bunl_in;
      t_ff       <= t_in;
      tunl_ff    <= tunl_in;
      grant_ff   <= grant_in;
      blocked_ff <= blocked_in;
      deliver_ff <= deliver_in;
      rgrant_ff  <= rgrant_in;
      rblk_ff    <= rblk_in;
      rwait_ff   <= rwait_in;
      rinf_ff    <= rinf_in;
      rdel_ff    <= rdel_in;
      rwflag_ff  <= rwflag_in;
      rtotal_ff  <= rtotal_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[head_ff];
   end

   assign rsp_valid         = rv_ff;
   assign rsp_grant         = rgrant_ff;
   assign rsp_blocked       = rblk_ff;
   assign rsp_wait_ms       = rwait_ff;
   assign rsp_wait_infinite = rinf_ff;
   assign rsp_deliver_event = rdel_ff;
   assign rsp_waiting_flag  = rwflag_ff;
   assign rsp_total_bytes   = rtotal_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("ring count exceeds the slot count");

   a_blocked_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rblk_ff) |-> (rgrant_ff == '0))
      else $error("blocked response carries a grant");

   a_inf_no_wait: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rinf_ff) |-> (rwait_ff == '0))
      else $error("infinite wait response carries a wait time");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after taking a request");

endmodule

// ===== sv/sliding_window_bandwidth_shaper_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window bandwidth shaper top level
// Requests pass one at a time through the back end sequencer, which ends each
// request once the response register is free. Each expired slot is read and
// retired in turn; the first request after reset or a change of rate, mode,
// window or slot length first runs the two serial divisions of the trickle budget.
// Reset is synchronous and active high; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_bandwidth_shaper_top import swbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [LEN_W-1:0]      req_length,
   input  logic                  req_would_block,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEN_W-1:0]      rsp_grant,
   output logic                  rsp_blocked,
   output logic [WAIT_W-1:0]     rsp_wait_ms,
   output logic                  rsp_wait_infinite,
   output logic                  rsp_deliver_event,
   output logic                  rsp_waiting_flag,
   output logic [BYTE_W-1:0]     rsp_total_bytes
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   swbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_length      (req_length),
      .req_would_block (req_would_block),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   swbs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_grant         (rsp_grant),
      .rsp_blocked       (rsp_blocked),
      .rsp_wait_ms       (rsp_wait_ms),
      .rsp_wait_infinite (rsp_wait_infinite),
      .rsp_deliver_event (rsp_deliver_event),
      .rsp_waiting_flag  (rsp_waiting_flag),
      .rsp_total_bytes   (rsp_total_bytes)
   );

endmodule

// ===== sim/tb_sliding_window_bandwidth_shaper_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window bandwidth shaper testbench
// Drives ticks, transfer requests, completions and readiness events through
// the valid/ready request channel, predicts each response with a behavioral
// model of the shaper kept in the testbench, and compares every response field.
// Several register settings are visited, with bursty senders and a stalling
// receiver.
// ----------------------------------------------------------------------------
module tb_sliding_window_bandwidth_shaper_top;
   import swbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] NO_TIMER = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] grant;
      logic        blocked;
      logic [21:0] wait_ms;
      logic        wait_inf;
      logic        deliver;
      logic        waiting;
      logic [47:0] total;
   } shaper_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_func = '0;
   logic [LEN_W-1:0] req_length = '0;
   logic req_would_block = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [LEN_W-1:0] rsp_grant;
   logic rsp_blocked;
   logic [WAIT_W-1:0] rsp_wait_ms;
   logic rsp_wait_infinite;
   logic rsp_deliver_event;
   logic rsp_waiting_flag;
   logic [BYTE_W-1:0] rsp_total_bytes;

   sliding_window_bandwidth_shaper_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Shaper state mirrored by the predictor.
   logic [31:0] cfg_rate;
   logic        cfg_mode;
   logic [11:0] cfg_window;
   logic [15:0] cfg_slot;
   logic [15:0] cfg_latency;
   logic        cfg_read;
   logic [31:0] clk_ms;
   logic [47:0] slot_bytes [SLOTS];
   logic [31:0] slot_start [SLOTS];
   int          head, used_slots;
   logic [47:0] win_bytes;
   logic [31:0] last_xfer;
   logic        is_waiting, was_full_read;
   logic [31:0] last_grant;
   logic [47:0] moved_total;

   shaper_rsp_type expected_rsps[$];
   int errors = 0;
   int rsp_hold = 0;
   bit rsp_pattern_on = 1;
   bit sender_gaps = 1;

   function automatic logic [63:0] age_of(logic [31:0] t);
      logic [31:0] d;
      d = clk_ms - t;
      return {32'd0, d};
   endfunction

   function automatic int newest();
      return (head + used_slots - 1) % SLOTS;
   endfunction

   function automatic void drop_old_slots();
      logic [63:0] keep;
      keep = cfg_window * 64'd1000;
      while (used_slots > 0 && age_of(slot_start[head]) >= keep) begin
         win_bytes = (win_bytes - slot_bytes[head]) & M48;
         head = (head + 1) % SLOTS;
         used_slots--;
      end
   endfunction

   function automatic logic [63:0] allowance();
      logic [63:0] keep, per_win, per_slot, cap, taken;
      taken = 0;
      drop_old_slots();
      if (cfg_rate == 0) return NO_TIMER;
      cap = {32'd0, cfg_rate} * cfg_window;
      if (!cfg_mode) return cap <= win_bytes ? 0 : cap - win_bytes;
      keep = cfg_window * 64'd1000;
      per_win = keep / (cfg_slot != 0 ? cfg_slot : 16'd1);
      if (per_win == 0) per_win = 1;
      per_slot = cap / per_win;
      if (per_slot == 0) per_slot = 1;
      if (used_slots > 0 && age_of(slot_start[newest()]) < cfg_slot)
         taken = slot_bytes[newest()];
      return per_slot <= taken ? 0 : per_slot - taken;
   endfunction

   function automatic logic [63:0] bandwidth_wait();
      logic [63:0] e, keep;
      if (allowance() != 0 || used_slots == 0) return 0;
      if (!cfg_mode) begin
         keep = cfg_window * 64'd1000;
         e = age_of(slot_start[head]);
         return e >= keep ? 0 : keep - e;
      end
      e = age_of(slot_start[newest()]);
      return e >= cfg_slot ? 0 : cfg_slot - e;
   endfunction

   function automatic logic [63:0] gap_wait();
      logic [63:0] e;
      e = age_of(last_xfer);
      if (cfg_latency < e) return 0;
      if (cfg_read && was_full_read) return 0;
      return cfg_latency - e;
   endfunction

   function automatic logic [63:0] timer_ms();
      logic [63:0] b, l;
      if (cfg_rate == 0 && cfg_latency == 0) return NO_TIMER;
      if (!is_waiting) return NO_TIMER;
      b = bandwidth_wait();
      l = gap_wait();
      return b > l ? b : l;
   endfunction

   function automatic void log_transfer(logic [31:0] n);
      moved_total = (moved_total + n) & M48;
      last_xfer = clk_ms;
      if (used_slots == 0 ||
          (age_of(slot_start[newest()]) > cfg_slot && used_slots < SLOTS)) begin
         used_slots++;
         slot_start[newest()] = clk_ms;
         slot_bytes[newest()] = 0;
      end
      slot_bytes[newest()] = (slot_bytes[newest()] + n) & M48;
      win_bytes = (win_bytes + n) & M48;
   endfunction

   function automatic void shaper_reset();
      cfg_rate = 0; cfg_mode = 0; cfg_window = 10; cfg_slot = 100;
      cfg_latency = 0; cfg_read = 0; clk_ms = 0; head = 0; used_slots = 0;
      win_bytes = 0; last_xfer = 0; is_waiting = 0; was_full_read = 0;
      last_grant = 0; moved_total = 0;
   endfunction

   function automatic void shaper_config(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
         CSR_RATE: begin cfg_rate = v; head = 0; used_slots = 0; win_bytes = 0; end
         CSR_MODE: begin cfg_mode = v[0]; head = 0; used_slots = 0; win_bytes = 0; end
         CSR_WINDOW: begin
            cfg_window = v[11:0]; head = 0; used_slots = 0; win_bytes = 0;
         end
         CSR_SLOT: begin
            cfg_slot = v[15:0]; head = 0; used_slots = 0; win_bytes = 0;
         end
         CSR_LATENCY: begin cfg_latency = v[15:0]; last_xfer = clk_ms; end
         CSR_READ: cfg_read = v[0];
         default: ;
      endcase
   endfunction

   function automatic shaper_rsp_type shaper_step(func_type f, logic [31:0] len, logic wb);
      shaper_rsp_type r;
      logic [63:0] mx, t;
      logic [31:0] moved;
      r = '0;
      case (f)
         FUNC_TICK: clk_ms++;
         FUNC_REQ: begin
            mx = gap_wait() == 0 ? allowance() : 0;
            if (mx > 0) begin
               is_waiting = 0;
               if (cfg_read) was_full_read = 1;
               if ({32'd0, len} > mx) begin
                  is_waiting = 1;
                  was_full_read = 0;
                  r.grant = mx[31:0];
               end else begin
                  r.grant = len;
               end
            end else begin
               is_waiting = 1;
               r.blocked = 1;
            end
            last_grant = r.grant;
         end
         FUNC_CMP: begin
            moved = len > last_grant ? last_grant : len;
            if (wb) begin
               was_full_read = 0;
               is_waiting = cfg_latency != 0;
            end else begin
               log_transfer(moved);
               if (moved < last_grant) begin
                  was_full_read = 0;
                  is_waiting = cfg_latency != 0;
               end
            end
         end
         default: begin
            t = timer_ms();
            if (t == 0) begin
               r.deliver = 1;
               is_waiting = 0;
            end else if (t == NO_TIMER) begin
               r.deliver = 1;
            end
         end
      endcase
      t = timer_ms();
      r.wait_inf = t == NO_TIMER;
      r.wait_ms = t == NO_TIMER ? 22'd0 : t[21:0];
      r.waiting = is_waiting;
      r.total = moved_total;
      return r;
   endfunction

   // Receiver stall pattern and response checker.
   int idle_cycles = 0;
   always @(posedge clock) begin
      shaper_rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_hold > 0) begin
            rsp_ready <= 0;
            rsp_hold <= rsp_hold - 1;
         end else if (rsp_pattern_on) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= 1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_grant !== e.grant) begin
                  $error("grant exp %0d got %0d", e.grant, rsp_grant); errors++;
               end
               if (rsp_blocked !== e.blocked) begin
                  $error("blocked exp %0d got %0d", e.blocked, rsp_blocked); errors++;
               end
               if (rsp_wait_ms !== e.wait_ms) begin
                  $error("wait_ms exp %0d got %0d", e.wait_ms, rsp_wait_ms); errors++;
               end
               if (rsp_wait_infinite !== e.wait_inf) begin
                  $error("wait_infinite exp %0d got %0d", e.wait_inf, rsp_wait_infinite);
                  errors++;
               end
               if (rsp_deliver_event !== e.deliver) begin
                  $error("deliver_event exp %0d got %0d", e.deliver, rsp_deliver_event);
                  errors++;
               end
               if (rsp_waiting_flag !== e.waiting) begin
                  $error("waiting_flag exp %0d got %0d", e.waiting, rsp_waiting_flag);
                  errors++;
               end
               if (rsp_total_bytes !== e.total) begin
                  $error("total_bytes exp %0d got %0d", e.total, rsp_total_bytes);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_request(func_type f, logic [31:0] len, logic wb);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_length <= len;
      req_would_block <= wb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(shaper_step(f, len, wb));
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      shaper_config(idx, v);
   endtask

   task automatic set_profile(logic [31:0] rate, logic mode, logic [11:0] win,
                              logic [15:0] slot, logic [15:0] lat, logic rd);
      drain();
      write_reg(CSR_RATE, rate);
      write_reg(CSR_MODE, {31'd0, mode});
      write_reg(CSR_WINDOW, {20'd0, win});
      write_reg(CSR_SLOT, {16'd0, slot});
      write_reg(CSR_LATENCY, {16'd0, lat});
      write_reg(CSR_READ, {31'd0, rd});
      csr_write_en <= 0;
   endtask

   // A transfer cycle: request, completion, then events and ticks.
   task automatic transfer_cycle(int max_len);
      logic [31:0] len;
      int r;
      len = $urandom_range(0, max_len);
      send_request(FUNC_REQ, len, 0);
      r = $urandom_range(0, 9);
      if (r < 6) send_request(FUNC_CMP, last_grant, 0);
      else if (r < 8) send_request(FUNC_CMP, $urandom_range(0, max_len), 0);
      else send_request(FUNC_CMP, $urandom(), 1);
      if ($urandom_range(0, 1))
         send_request(FUNC_EVT, $urandom(), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 4))
         send_request(FUNC_TICK, $urandom(), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed();
      send_request(FUNC_EVT, 0, 0);
      send_request(FUNC_REQ, 32'hFFFF_FFFF, 1);
      send_request(FUNC_CMP, 32'hFFFF_FFFF, 0);
      send_request(FUNC_CMP, 0, 1);
      send_request(FUNC_TICK, 32'hFFFF_FFFF, 1);
      set_profile(1000, 0, 1, 15, 5, 1);
      send_request(FUNC_REQ, 1500, 0);
      send_request(FUNC_CMP, 2000, 0);
      send_request(FUNC_REQ, 10, 0);
      send_request(FUNC_EVT, 0, 0);
      repeat (3) send_request(FUNC_TICK, 0, 0);
      send_request(FUNC_EVT, 0, 0);
      send_request(FUNC_REQ, 0, 0);
      set_profile(1, 1, 3600, 0, 0, 0);
      send_request(FUNC_REQ, 5, 0);
      send_request(FUNC_CMP, 1, 0);
      send_request(FUNC_REQ, 5, 0);
      send_request(FUNC_EVT, 0, 0);
      set_profile(5000, 1, 0, 15, 0, 0);
      repeat (6) transfer_cycle(100);
      set_profile(32'hFFFF_FFFF, 1, 12'hFFF, 16'hFFFF, 16'hFFFF, 1);
      send_request(FUNC_REQ, 32'hFFFF_FFFF, 0);
      send_request(FUNC_CMP, 32'hFFFF_FFFF, 0);
      send_request(FUNC_EVT, 0, 0);
   endtask

   task automatic test_burst_window();
      set_profile(2000, 0, 1, 100, 0, 0);
      repeat (20) transfer_cycle(800);
   endtask

   task automatic test_trickle_slots();
      set_profile(5000, 1, 2, 20, 3, 1);
      repeat (20) transfer_cycle(400);
   endtask

   task automatic test_full_ring();
      set_profile(32'd100000, 0, 1, 0, 0, 0);
      send_request(FUNC_REQ, 32'd5000, 0);
      repeat (132) begin
         if ($urandom_range(0, 3) == 0) send_request(FUNC_REQ, $urandom_range(1, 50), 0);
         send_request(FUNC_CMP, $urandom_range(0, 60), 0);
         send_request(FUNC_TICK, 0, 0);
      end
   endtask

   task automatic test_backpressure();
      set_profile(3000, 1'($urandom_range(0, 1)), 1, 50, 2, 0);
      sender_gaps = 0;
      rsp_hold = 300;
      repeat (20) transfer_cycle(1000);
      sender_gaps = 1;
      drain();
   endtask

   task automatic test_random_mix();
      int k;
      set_profile($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 20000)),
                  1'($urandom_range(0, 1)), 12'($urandom_range(1, 4)),
                  16'($urandom_range(15, 300)), 16'($urandom_range(0, 10)),
                  1'($urandom_range(0, 1)));
      for (k = 0; k < 40; k++) begin
         if ($urandom_range(0, 9) < 8) transfer_cycle($urandom_range(0, 1) ? 500 : 70000);
         else send_request(func_type'(2'($urandom_range(0, 3))), $urandom(),
                           1'($urandom_range(0, 1)));
         if (k == 15) rsp_pattern_on = 0;
         if (k == 30) rsp_pattern_on = 1;
      end
   endtask

   initial begin
      shaper_reset();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_burst_window();
      test_trickle_slots();
      test_full_ring();
      test_backpressure();
      test_random_mix();
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sliding_window_bandwidth_shaper_top.f =====
sv/swbs_pkg.sv
sv/swbs_div.sv
sv/swbs_front.sv
sv/swbs_back.sv
sv/sliding_window_bandwidth_shaper_top.sv
sim/tb_sliding_window_bandwidth_shaper_top.sv
